FILE: sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, types and helpers of the sliding-window mean block.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Deepest window the ring buffer can hold.
  localparam int MAX_PERIOD = 256;

  // Field widths of the streams and the configuration register.
  localparam int SAMPLE_W = 16;
  localparam int PERIOD_W = 9;
  localparam int MEAN_W   = 24;
  localparam int COUNT_W  = 9;
  localparam int FRAC_W   = 8;

  // Internal widths that follow from the window depth.
  localparam int SLOT_W = $clog2(MAX_PERIOD);
  localparam int CNT_W  = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W  = SAMPLE_W + SLOT_W;
  localparam int DIVD_W = SUM_W + FRAC_W;
  localparam int DCNT_W = $clog2(DIVD_W);

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MEAN_W + COUNT_W + 7) / 8) * 8;

  // Period after reset.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(16);

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RING,
    ST_DIV,
    ST_HOLD
  } swm_state_t;

  // Result of one ring-buffer update.
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        fill;
  } ring_res_t;

  // Result of one division.
  typedef struct packed {
    logic                     done;
    logic signed [MEAN_W-1:0] mean;
  } div_res_t;

  // Period register clamped to the range 1 .. MAX_PERIOD.
  function automatic logic [CNT_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    logic [CNT_W-1:0] r;
    if (p == '0) begin
      r = CNT_W'(1);
    end else if (32'(p) > MAX_PERIOD) begin
      r = CNT_W'(MAX_PERIOD);
    end else begin
      r = CNT_W'(p);
    end
    return r;
  endfunction

endpackage

FILE: sv/sliding_window_mean.sv
// ----------------------------------------------------------------------------
// sliding_window_mean
// Simple moving average of signed 16-bit samples, in Q8, with window count.
// ----------------------------------------------------------------------------
// Each sample gives one result: the mean of the last period samples (fewer
// while the window fills) as sum * 256 / count truncated toward zero, and
// the count. A sample goes through these steps before the next can be
// accepted: a read of the oldest sample from the window memory, a
// write-back that updates the running sum, a hand-over, the bit-serial
// divider (one quotient bit per cycle over the 32-bit scaled sum), and a
// load of the output register. The output register lets a new sample enter
// while a result waits to be taken. Writing the period empties the window;
// it is accepted at any time and must only be written while no sample is in
// flight.
module sliding_window_mean (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [swm_pkg::IN_TDATA_W-1:0]       in_tdata,   // [15:0] sample
  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [swm_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [23:0] mean_q8,
                                                            // [32:24] count
  // Period register write.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::PERIOD_W-1:0]         cfg_data
);
  import swm_pkg::*;

  swm_state_t               state_r, state_nxt;
  ring_res_t                ring_res;
  div_res_t                 div_res;
  logic                     in_acc;
  logic                     cfg_we;
  logic                     div_start;
  logic                     out_load;
  logic                     out_free;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_tvalid_r;
  logic signed [MEAN_W-1:0] out_mean_r;
  logic [COUNT_W-1:0]       out_count_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  swm_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_period (cfg_data),
    .start      (in_acc),
    .sample     ($signed(in_tdata[SAMPLE_W-1:0])),
    .res        (ring_res)
  );

  swm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({ring_res.sum, FRAC_W'(0)}),
    .divisor  (ring_res.fill),
    .res      (div_res)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_RING;
        end
      end
      ST_RING: begin
        if (ring_res.valid) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Count of the sample in flight.
  always_ff @(posedge clk) begin
    if (ring_res.valid) begin
      cnt_r <= ring_res.fill;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r  <= div_res.mean;
      out_count_r <= COUNT_W'(cnt_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_mean_r});

endmodule

FILE: sv/swm_ring.sv
// ----------------------------------------------------------------------------
// swm_ring
// Window memory with running sum, fill count and write pointer. Each sample
// takes a read step followed by a read-modify-write step.
// ----------------------------------------------------------------------------
module swm_ring (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [swm_pkg::PERIOD_W-1:0]         cfg_period,
  input  logic                                 start,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  output swm_pkg::ring_res_t                   res
);
  import swm_pkg::*;

  logic [SAMPLE_W-1:0]        mem [MAX_PERIOD];
  logic [SAMPLE_W-1:0]        rd_r;

  logic [PERIOD_W-1:0]        period_r;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       busy_r;
  logic                       done_r;
  logic [SLOT_W-1:0]          addr_r;
  logic signed [SAMPLE_W-1:0] samp_r;

  logic [CNT_W-1:0]           p_eff;
  logic [SLOT_W-1:0]          eff_slot;
  logic [CNT_W-1:0]           slot_inc;
  logic                       full;
  logic signed [SUM_W-1:0]    sum_sub;

  // Clamped period and the slot the next sample goes to.
  assign p_eff    = eff_period(period_r);
  assign eff_slot = (CNT_W'(slot_r) >= p_eff) ? '0 : slot_r;

  // Update of sum, count and pointer from the oldest sample read back.
  always_comb begin
    full     = (fill_r >= p_eff);
    sum_sub  = full ? (sum_r - SUM_W'($signed(rd_r))) : sum_r;
    sum_nxt  = sum_sub + SUM_W'(samp_r);
    fill_nxt = full ? p_eff : (fill_r + CNT_W'(1));
    slot_inc = CNT_W'(addr_r) + CNT_W'(1);
    slot_nxt = (slot_inc >= p_eff) ? '0 : slot_inc[SLOT_W-1:0];
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    rd_r <= mem[eff_slot];
    if (busy_r) begin
      mem[addr_r] <= samp_r;
    end
  end

  // Captured sample and slot for the write-back cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= eff_slot;
      samp_r <= sample;
    end
  end

  // Control state and running totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      slot_r   <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= busy_r;
      busy_r <= start;
      if (cfg_we) begin
        period_r <= cfg_period;
        slot_r   <= '0;
        fill_r   <= '0;
        sum_r    <= '0;
      end else if (busy_r) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  assign res.valid = done_r;
  assign res.sum   = sum_r;
  assign res.fill  = fill_r;

  // The count never exceeds the clamped period.
  a_fill_le_period: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= p_eff)
    else $error("fill count above period");

  // The write pointer stays inside the active window.
  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(slot_r) < p_eff)
    else $error("write slot outside window");

  // A write-back is followed by a result holding at least one sample.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !cfg_we |=> done_r && (fill_r != '0))
    else $error("ring update did not complete");

endmodule

FILE: sv/swm_div.sv
// ----------------------------------------------------------------------------
// swm_div
// Radix-2 restoring divider, one quotient bit per cycle, for the scaled sum
// divided by the fill count. The quotient is truncated toward zero.
// ----------------------------------------------------------------------------
module swm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [swm_pkg::DIVD_W-1:0]  dividend,
  input  logic [swm_pkg::CNT_W-1:0]          divisor,
  output swm_pkg::div_res_t                  res
);
  import swm_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [DCNT_W-1:0]        cnt_r;
  logic                     neg_r;
  logic [DIVD_W-1:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         dsr_r;
  logic signed [MEAN_W-1:0] mean_r;

  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           diff;
  logic                     ge;
  logic [DIVD_W-1:0]        mag;
  logic [MEAN_W-1:0]        q_mag;

  // Magnitude of the dividend at start.
  assign mag = dividend[DIVD_W-1] ? (DIVD_W'(0) - dividend) : dividend;

  // One shift-subtract step.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVD_W-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
    q_mag   = quo_nxt[MEAN_W-1:0];
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= dividend[DIVD_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == '0) begin
        mean_r <= neg_r ? (MEAN_W'(0) - q_mag) : q_mag;
      end
    end
  end

  // Step counter and handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - DCNT_W'(1);
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.mean = mean_r;

  // A new division never starts over one in progress.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("divider started while busy");

  // The last step is followed by the done pulse.
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r == '0) && !start |=> done_r && !busy_r)
    else $error("divider missed its final step");

  // The divisor is never zero while dividing.
  a_divisor_nz: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> dsr_r != '0)
    else $error("division by zero count");

endmodule
